>>> hw/rtl/lcdr_pkg.sv
// lcdr_pkg: shared types, codes and constants for the character LCD refresh controller.
// No dependencies; imported by every lcdr module.
package lcdr_pkg;

    // default geometry
    localparam int LCDR_ROWS    = 2;
    localparam int LCDR_COLUMNS = 16;

    // register reset values (ms)
    localparam logic [7:0] PWR_WAIT_RST   = 8'd15;
    localparam logic [7:0] WAKE_WAIT_RST  = 8'd5;
    localparam logic [7:0] CLEAR_WAIT_RST = 8'd2;
    localparam logic [7:0] STEP_WAIT_RST  = 8'd1;

    // configuration register indexes
    localparam logic [1:0] CFG_PWR_WAIT   = 2'd0;
    localparam logic [1:0] CFG_WAKE_WAIT  = 2'd1;
    localparam logic [1:0] CFG_CLEAR_WAIT = 2'd2;
    localparam logic [1:0] CFG_STEP_WAIT  = 2'd3;

    // request kinds
    localparam logic REQ_TIME = 1'b0;
    localparam logic REQ_TEXT = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVALID  = 2'd1;
    localparam logic [1:0] STAT_CAPACITY = 2'd2;

    // start-up phases
    localparam logic [3:0] PH_POWER = 4'd0;
    localparam logic [3:0] PH_WAKE  = 4'd1;
    localparam logic [3:0] PH_BYTES = 4'd4;  // first phase that sends a full byte
    localparam logic [3:0] PH_CLEAR = 4'd7;  // wait after the clear command
    localparam logic [3:0] PH_FINAL = 4'd9;  // closing step, no nibbles
    localparam logic [3:0] PH_READY = 4'd10;

    // characters and commands
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TILDE      = 8'h7E;
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
    localparam logic [7:0] ROW1_BASE     = 8'h40;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] NIB_WAKE      = 8'h03;
    localparam logic [7:0] NIB_FOUR_BIT  = 8'h02;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_SCAN,
        ST_EMIT,
        ST_COMMIT,
        ST_TXTRES
    } t_state;

    // byte (or single nibble in the low half) sent at each start-up phase
    function automatic logic [7:0] lcdr_init_byte(input logic [3:0] phase);
        logic [7:0] b;
        case (phase)
            4'd0, 4'd1, 4'd2: b = NIB_WAKE;
            4'd3:             b = NIB_FOUR_BIT;
            4'd4:             b = CMD_FUNC_SET;
            4'd5:             b = CMD_DISP_OFF;
            4'd6:             b = CMD_CLEAR;
            4'd7:             b = CMD_ENTRY;
            4'd8:             b = CMD_DISP_ON;
            default:          b = CH_NUL;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/lcdr_cell_mem.sv
// lcdr_cell_mem: one-write one-read cell store, registered read, per-entry valid bits.
// Entries never written read as RST_VAL. Uses lcdr_pkg.
module lcdr_cell_mem
    import lcdr_pkg::*;
#(
    parameter int         DEPTH   = LCDR_ROWS * LCDR_COLUMNS,
    parameter int         AW      = 5,
    parameter logic [7:0] RST_VAL = CH_SPACE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : RST_VAL;

endmodule

>>> hw/rtl/lcdr_stage_mem.sv
// lcdr_stage_mem: staging buffer for one row of text, registered read, no reset.
// Uses lcdr_pkg for the default depth.
module lcdr_stage_mem
    import lcdr_pkg::*;
#(
    parameter int DEPTH = LCDR_COLUMNS,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/char_lcd_refresh_controller_unit.sv
// char_lcd_refresh_controller_unit: top level, sequencer, config registers, cell stores.
// Depends on lcdr_pkg, lcdr_cell_mem, lcdr_stage_mem.
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+---------------------------
//  request   | i_req_type i_now_ms i_row i_text_byte          | start & !busy
//  result    | o_nibble_valid o_register_select o_nibble      | o_strobe, one cycle, taken
//            | o_status o_last                                |   at once (no back-pressure)
//  config    | i_cfg_we i_cfg_idx i_cfg_wdata                 | i_cfg_we, no wait
//
// A non-zero text byte is absorbed in the accept cycle (busy stays low).
// A time update during start-up passes an update state, then sends 0, 1 or 2 nibbles.
// A refresh update passes a set-up state, then scans the ROWS*COLUMNS cells one cell
// per cycle through the registered read port until the first differing cell, which it
// sends as 4 nibbles (address command, then character); else it returns to idle.
// A terminating zero byte copies the staged row through the staging RAM read port,
// then gives one result; with an error, only the result.
// Reset (synchronous, active low) clears control state and cell valid bits at once;
// no clearing pass. Results leave through an output register, in the cycle after issue.
module char_lcd_refresh_controller_unit
    import lcdr_pkg::*;
#(
    parameter int ROWS    = LCDR_ROWS,
    parameter int COLUMNS = LCDR_COLUMNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [31:0] i_now_ms,
    input  logic        i_row,
    input  logic [7:0]  i_text_byte,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    // result
    output logic        o_strobe,
    output logic        o_nibble_valid,
    output logic        o_register_select,
    output logic [3:0]  o_nibble,
    output logic [1:0]  o_status,
    output logic        o_last
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COLW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CNTW  = $clog2(COLUMNS + 1);
    localparam int SCW   = $clog2(CELLS + 1);
    localparam logic [COLW-1:0] LAST_COL = COLW'(COLUMNS - 1);
    localparam logic            LAST_ROW = 1'(ROWS - 1);

    t_state r_state, n_state;

    // configuration
    logic [7:0] r_pw, r_ww, r_cw, r_sw;

    // request capture
    logic [31:0] r_now;
    logic        r_row;
    logic [1:0]  r_status;

    // start-up
    logic [3:0]  r_phase;
    logic        r_anchor_vld;
    logic [31:0] r_anchor;

    // refresh scan: issue side (s) and compare side (p)
    logic            r_ptr_row;
    logic [COLW-1:0] r_ptr_col;
    logic            r_s_row;
    logic [COLW-1:0] r_s_col;
    logic [SCW-1:0]  r_s_cnt;
    logic            r_p_vld;
    logic            r_p_row;
    logic [COLW-1:0] r_p_col;

    // nibble emitter
    logic [15:0] r_emit;
    logic [3:0]  r_emit_rs;
    logic [1:0]  r_left;

    // text staging and commit
    logic [CNTW-1:0] r_stg_cnt;
    logic [1:0]      r_stg_err;
    logic [CNTW-1:0] r_c_cnt;
    logic            r_q_vld;
    logic [COLW-1:0] r_q_col;

    // output register
    logic       r_o_strobe, n_o_strobe;
    logic       r_o_nv,     n_o_nv;
    logic       r_o_rs,     n_o_rs;
    logic [3:0] r_o_nib,    n_o_nib;
    logic [1:0] r_o_st,     n_o_st;
    logic       r_o_last,   n_o_last;

    // memory ports
    logic            w_wm_we;
    logic [CAW-1:0]  w_wm_waddr;
    logic [7:0]      w_wm_wdata;
    logic            w_sh_we;
    logic [CAW-1:0]  w_sh_waddr;
    logic [CAW-1:0]  w_cell_raddr;
    logic [7:0]      w_want_rd;
    logic [7:0]      w_shown_rd;
    logic            w_stg_we;
    logic [7:0]      w_stg_rd;

    // misc combinational
    logic            w_acc;
    logic            w_text_char;
    logic [1:0]      w_txt_st;
    logic [31:0]     w_elapsed;
    logic [7:0]      w_wait;
    logic            w_due;
    logic            w_found;
    logic            w_scan_done;
    logic            w_cmt_done;
    logic            w_s_nrow, w_p_nrow;
    logic [COLW-1:0] w_s_ncol, w_p_ncol;
    logic [7:0]      w_addr_cmd;
    logic [7:0]      w_init_byte;

    assign busy        = (r_state != ST_IDLE);
    assign w_acc       = start && !busy;
    assign w_text_char = (i_req_type == REQ_TEXT) && (i_text_byte != CH_NUL);
    // row check wins over a staged error
    assign w_txt_st    = (int'(i_row) >= ROWS) ? STAT_INVALID : r_stg_err;

    // start-up timing: due once (now - anchor) lies in [wait, 2^31)
    always_comb begin
        case (r_phase)
            PH_POWER: w_wait = r_pw;
            PH_WAKE:  w_wait = r_ww;
            PH_CLEAR: w_wait = r_cw;
            default:  w_wait = r_sw;
        endcase
    end
    assign w_elapsed   = r_now - r_anchor;
    assign w_due       = !w_elapsed[31] && (w_elapsed >= {24'd0, w_wait});
    assign w_init_byte = lcdr_init_byte(r_phase);

    // scan position stepping, row-major with wrap
    assign w_s_ncol = (r_s_col == LAST_COL) ? '0 : r_s_col + 1'b1;
    assign w_s_nrow = (r_s_col == LAST_COL) ? ((r_s_row == LAST_ROW) ? 1'b0 : ~r_s_row)
                                            : r_s_row;
    assign w_p_ncol = (r_p_col == LAST_COL) ? '0 : r_p_col + 1'b1;
    assign w_p_nrow = (r_p_col == LAST_COL) ? ((r_p_row == LAST_ROW) ? 1'b0 : ~r_p_row)
                                            : r_p_row;

    assign w_found     = r_p_vld && (w_want_rd != w_shown_rd);
    assign w_scan_done = (r_s_cnt == SCW'(CELLS)) && !r_p_vld;
    assign w_cmt_done  = (r_c_cnt == CNTW'(COLUMNS)) && !r_q_vld;
    assign w_addr_cmd  = CMD_SET_ADDR | (r_p_row ? ROW1_BASE : CH_NUL) | 8'(r_p_col);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_req_type == REQ_TIME) begin
                        n_state = ST_UPD;
                    end else if (i_text_byte == CH_NUL) begin
                        n_state = (w_txt_st == STAT_OK) ? ST_COMMIT : ST_TXTRES;
                    end
                end
            end
            ST_UPD: begin
                if (r_phase < PH_READY) begin
                    if (r_anchor_vld && w_due && (r_phase != PH_FINAL)) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_found) begin
                    n_state = ST_EMIT;
                end else if (w_scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (r_left == 2'd0) begin
                    n_state = ST_IDLE;
                end
            end
            ST_COMMIT: begin
                if (w_cmt_done) begin
                    n_state = ST_TXTRES;
                end
            end
            ST_TXTRES: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs: memory controls and the next result
    always_comb begin
        w_cell_raddr = (r_s_row ? CAW'(COLUMNS) : '0) + CAW'(r_s_col);
        w_sh_we      = (r_state == ST_SCAN) && w_found;
        w_sh_waddr   = (r_p_row ? CAW'(COLUMNS) : '0) + CAW'(r_p_col);
        w_wm_we      = (r_state == ST_COMMIT) && r_q_vld;
        w_wm_waddr   = (r_row ? CAW'(COLUMNS) : '0) + CAW'(r_q_col);
        // cells past the staged text are padded with spaces
        w_wm_wdata   = (CNTW'(r_q_col) < r_stg_cnt) ? w_stg_rd : CH_SPACE;
        w_stg_we     = (r_state == ST_IDLE) && w_acc && w_text_char &&
                       (r_stg_cnt < CNTW'(COLUMNS));
        n_o_strobe   = (r_state == ST_EMIT) || (r_state == ST_TXTRES);
        n_o_nv       = (r_state == ST_EMIT);
        n_o_rs       = (r_state == ST_EMIT) && r_emit_rs[3];
        n_o_nib      = (r_state == ST_EMIT) ? r_emit[15:12] : 4'd0;
        n_o_st       = (r_state == ST_TXTRES) ? r_status : STAT_OK;
        n_o_last     = (r_state == ST_TXTRES) || ((r_state == ST_EMIT) && (r_left == 2'd0));
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw <= PWR_WAIT_RST;
            r_ww <= WAKE_WAIT_RST;
            r_cw <= CLEAR_WAIT_RST;
            r_sw <= STEP_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PWR_WAIT:   r_pw <= i_cfg_wdata;
                CFG_WAKE_WAIT:  r_ww <= i_cfg_wdata;
                CFG_CLEAR_WAIT: r_cw <= i_cfg_wdata;
                CFG_STEP_WAIT:  r_sw <= i_cfg_wdata;
                default:        r_pw <= r_pw;
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_POWER;
            r_anchor_vld <= 1'b0;
            r_anchor     <= '0;
            r_ptr_row    <= 1'b0;
            r_ptr_col    <= '0;
            r_stg_cnt    <= '0;
            r_stg_err    <= STAT_OK;
            r_p_vld      <= 1'b0;
            r_q_vld      <= 1'b0;
            r_o_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_o_strobe <= n_o_strobe;
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_now    <= i_now_ms;
                        r_row    <= i_row;
                        r_status <= w_txt_st;
                        r_c_cnt  <= '0;
                        r_q_vld  <= 1'b0;
                        if (w_text_char) begin
                            if (r_stg_cnt < CNTW'(COLUMNS)) begin
                                if ((r_stg_err == STAT_OK) &&
                                    ((i_text_byte < CH_SPACE) || (i_text_byte > CH_TILDE))) begin
                                    r_stg_err <= STAT_INVALID;
                                end
                                r_stg_cnt <= r_stg_cnt + 1'b1;
                            end else if (r_stg_err == STAT_OK) begin
                                r_stg_err <= STAT_CAPACITY;
                            end
                        end
                    end
                end
                ST_UPD: begin
                    if (r_phase < PH_READY) begin
                        if (!r_anchor_vld) begin
                            // first update only sets the anchor
                            r_anchor     <= r_now;
                            r_anchor_vld <= 1'b1;
                        end else if (w_due) begin
                            if (r_phase == PH_FINAL) begin
                                r_phase <= PH_READY;
                            end else begin
                                r_phase   <= r_phase + 1'b1;
                                r_anchor  <= r_now;
                                r_emit_rs <= 4'b0000;
                                if (r_phase < PH_BYTES) begin
                                    r_emit <= {w_init_byte[3:0], 12'h000};
                                    r_left <= 2'd0;
                                end else begin
                                    r_emit <= {w_init_byte, 8'h00};
                                    r_left <= 2'd1;
                                end
                            end
                        end
                    end else begin
                        r_s_row <= r_ptr_row;
                        r_s_col <= r_ptr_col;
                        r_s_cnt <= '0;
                        r_p_vld <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (w_found) begin
                        // differing cell: stop the scan, pointer moves past it
                        r_p_vld   <= 1'b0;
                        r_ptr_row <= w_p_nrow;
                        r_ptr_col <= w_p_ncol;
                        r_emit    <= {w_addr_cmd, w_want_rd};
                        r_emit_rs <= 4'b0011;
                        r_left    <= 2'd3;
                    end else if (r_s_cnt != SCW'(CELLS)) begin
                        r_s_row <= w_s_nrow;
                        r_s_col <= w_s_ncol;
                        r_s_cnt <= r_s_cnt + 1'b1;
                        r_p_vld <= 1'b1;
                        r_p_row <= r_s_row;
                        r_p_col <= r_s_col;
                    end else begin
                        r_p_vld <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    r_emit    <= {r_emit[11:0], 4'h0};
                    r_emit_rs <= {r_emit_rs[2:0], 1'b0};
                    r_left    <= r_left - 1'b1;
                end
                ST_COMMIT: begin
                    if (r_c_cnt != CNTW'(COLUMNS)) begin
                        r_c_cnt <= r_c_cnt + 1'b1;
                        r_q_vld <= 1'b1;
                        r_q_col <= r_c_cnt[COLW-1:0];
                    end else begin
                        r_q_vld <= 1'b0;
                    end
                end
                ST_TXTRES: begin
                    r_stg_cnt <= '0;
                    r_stg_err <= STAT_OK;
                end
                default: r_p_vld <= 1'b0;
            endcase
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        r_o_nv   <= n_o_nv;
        r_o_rs   <= n_o_rs;
        r_o_nib  <= n_o_nib;
        r_o_st   <= n_o_st;
        r_o_last <= n_o_last;
    end

    assign o_strobe          = r_o_strobe;
    assign o_nibble_valid    = r_o_nv;
    assign o_register_select = r_o_rs;
    assign o_nibble          = r_o_nib;
    assign o_status          = r_o_st;
    assign o_last            = r_o_last;

    // wanted characters, spaces after reset
    lcdr_cell_mem #(
        .DEPTH   (CELLS),
        .AW      (CAW),
        .RST_VAL (CH_SPACE)
    ) u_wanted (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_wm_we),
        .i_waddr (w_wm_waddr),
        .i_wdata (w_wm_wdata),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_want_rd)
    );

    // characters on the glass, zero after reset
    lcdr_cell_mem #(
        .DEPTH   (CELLS),
        .AW      (CAW),
        .RST_VAL (CH_NUL)
    ) u_shown (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_sh_we),
        .i_waddr (w_sh_waddr),
        .i_wdata (w_want_rd),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_shown_rd)
    );

    lcdr_stage_mem #(
        .DEPTH (COLUMNS),
        .AW    (COLW)
    ) u_stage (
        .i_clk   (i_clk),
        .i_we    (w_stg_we),
        .i_waddr (r_stg_cnt[COLW-1:0]),
        .i_wdata (i_text_byte),
        .i_raddr (r_c_cnt[COLW-1:0]),
        .o_rdata (w_stg_rd)
    );

    // a text result never carries a nibble and always closes its request
    a_text_res_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_nibble_valid) |-> o_last)
        else $error("text result without last");

    // nibble results report ok
    a_nib_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_nibble_valid) |-> (o_status == STAT_OK))
        else $error("nibble result with non-zero status");

    // refresh scan only once start-up is over
    a_scan_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_phase >= PH_READY))
        else $error("scan before start-up finished");

    // commit only for an error-free staged row
    a_commit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) |-> (r_stg_err == STAT_OK))
        else $error("commit with staged error");

    // a request's last result is never followed directly by another result
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result straight after last");

endmodule
